FILE: hw/rtl/bitmap_id_allocator_assert.svh
// Assertion macros for the bitmap identifier allocator
`ifndef BITMAP_ID_ALLOCATOR_ASSERT_SVH
`define BITMAP_ID_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BIA_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bitmap_id_allocator: check failed");

// next-cycle implication
`define BIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bitmap_id_allocator: check failed");

`endif

FILE: hw/rtl/bia_pkg.sv
// Constants, codes and types shared by the bitmap identifier allocator
package bia_pkg;

   localparam int MAX_IDS       = 1024;
   localparam int BITS_PER_WORD = 32;
   localparam int WORD_COUNT    = (MAX_IDS + BITS_PER_WORD - 1) / BITS_PER_WORD;
   localparam int WORD_ADDR_W   = $clog2(WORD_COUNT);
   localparam int BIT_IDX_W     = $clog2(BITS_PER_WORD);

   localparam int KIND_W    = 3;
   localparam int ELEMENT_W = 10;
   localparam int LIMIT_W   = 11;
   localparam int STATUS_W  = 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);
   localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(MAX_IDS);

   localparam logic [KIND_W-1:0] KIND_SET       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd1;
   localparam logic [KIND_W-1:0] KIND_TEST      = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ALLOC     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_CLEAR_ALL = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic                   wr;
      logic                   clear_all;
      logic [WORD_ADDR_W-1:0] addr;
      logic                   full;
   } sum_upd_type;

   typedef struct packed {
      logic                   word_valid;
      logic                   free_found;
      logic [WORD_ADDR_W-1:0] free_word;
   } sum_info_type;

endpackage

FILE: hw/rtl/bia_if.sv
// Request and response channel interfaces of the bitmap identifier allocator
interface bia_req_if;
   logic                          valid;
   logic                          ready;
   logic [bia_pkg::KIND_W-1:0]    kind;
   logic [bia_pkg::ELEMENT_W-1:0] element;

   modport source (output valid, kind, element, input ready);
   modport sink   (input valid, kind, element, output ready);
endinterface

interface bia_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [bia_pkg::STATUS_W-1:0]  status;
   logic                          is_used;
   logic [bia_pkg::ELEMENT_W-1:0] granted_element;

   modport source (output valid, status, is_used, granted_element, input ready);
   modport sink   (input valid, status, is_used, granted_element, output ready);
endinterface

FILE: hw/rtl/bia_word_ram.sv
// Usage word memory: one write port, one registered read port
module bia_word_ram (
   input  logic                                clock,
   input  logic                                rd_en,
   input  logic [bia_pkg::WORD_ADDR_W-1:0]     rd_addr,
   output logic [bia_pkg::BITS_PER_WORD-1:0]   rd_data,
   input  logic                                wr_en,
   input  logic [bia_pkg::WORD_ADDR_W-1:0]     wr_addr,
   input  logic [bia_pkg::BITS_PER_WORD-1:0]   wr_data
);

   logic [bia_pkg::BITS_PER_WORD-1:0] mem [bia_pkg::WORD_COUNT];
   logic [bia_pkg::BITS_PER_WORD-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bia_summary.sv
// Word valid flags and full-word summary with lowest non-full word search
module bia_summary (
   input  logic                            clock,
   input  logic                            reset,
   input  bia_pkg::sum_upd_type            upd,
   input  logic [bia_pkg::WORD_ADDR_W-1:0] rd_addr,
   output bia_pkg::sum_info_type           info
);

   logic [bia_pkg::WORD_COUNT-1:0] valid_ff;
   logic [bia_pkg::WORD_COUNT-1:0] valid_in;
   logic [bia_pkg::WORD_COUNT-1:0] full_ff;
   logic [bia_pkg::WORD_COUNT-1:0] full_in;

   always_comb begin
      valid_in = valid_ff;
      full_in  = full_ff;
      if (upd.clear_all) begin
         valid_in = '0;
         full_in  = '0;
      end else if (upd.wr) begin
         valid_in[upd.addr] = 1'b1;
         full_in[upd.addr]  = upd.full;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         full_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         full_ff  <= full_in;
      end
   end

   // lowest word that still has a free bit
   always_comb begin
      info.free_found = 1'b0;
      info.free_word  = '0;
      for (int i = bia_pkg::WORD_COUNT - 1; i >= 0; i--) begin
         if (!full_ff[i]) begin
            info.free_found = 1'b1;
            info.free_word  = bia_pkg::WORD_ADDR_W'(i);
         end
      end
      info.word_valid = valid_ff[rd_addr];
   end

endmodule

FILE: hw/rtl/bitmap_id_allocator.sv
// Top level of the bitmap identifier allocator: request sequencer and response register
//
//   channel   dir   handshake           payload
//   req_port  in    valid/ready         kind, element
//   rsp_port  out   valid/ready         status, is_used, granted_element
//   csr_*     in    csr_we (no wait)    csr_wdata = element_limit
//
// Each request reads the word RAM on accept, then modifies the word and writes it back.
// The word RAM's single read-modify-write per request sets this order.
// Reset clears the bitmap at once through per-word valid flags; no clearing pass.
// A response waiting to be taken holds the next request in its modify and write-back step.
module bitmap_id_allocator (
   input  logic                          clock,
   input  logic                          reset,
   bia_req_if.sink                       req_port,
   bia_rsp_if.source                     rsp_port,
   input  logic                          csr_we,
   input  logic [bia_pkg::LIMIT_W-1:0]   csr_wdata
);

   `include "bitmap_id_allocator_assert.svh"

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic                                state_ff, state_in;
   logic [bia_pkg::LIMIT_W-1:0]         limit_ff, limit_in;
   logic [bia_pkg::KIND_W-1:0]          kind_ff;
   logic [bia_pkg::ELEMENT_W-1:0]       elem_ff;
   logic [bia_pkg::WORD_ADDR_W-1:0]     addr_ff;
   logic                                free_found_ff;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [bia_pkg::STATUS_W-1:0]        status_ff;
   logic                                used_ff;
   logic [bia_pkg::ELEMENT_W-1:0]       granted_ff;

   logic                                req_fire;
   logic                                rsp_fire;
   logic                                exec_go;
   logic [bia_pkg::WORD_ADDR_W-1:0]     rd_addr;
   logic [bia_pkg::BITS_PER_WORD-1:0]   ram_data;
   logic [bia_pkg::BITS_PER_WORD-1:0]   word;
   logic [bia_pkg::BITS_PER_WORD-1:0]   wr_word;
   logic [bia_pkg::BITS_PER_WORD-1:0]   bit_mask;
   logic [bia_pkg::BIT_IDX_W-1:0]       bit_idx;
   logic                                wr_en;
   logic [bia_pkg::LIMIT_W-1:0]         active_limit;
   logic                                in_range;
   logic                                zero_found;
   logic [bia_pkg::BIT_IDX_W-1:0]       zero_idx;
   logic [bia_pkg::ELEMENT_W-1:0]       cand;
   logic [bia_pkg::STATUS_W-1:0]        status_in;
   logic                                used_in;
   logic [bia_pkg::ELEMENT_W-1:0]       granted_in;
   bia_pkg::sum_upd_type                upd;
   bia_pkg::sum_info_type               info;

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_port.valid && req_port.ready;
   assign rsp_fire       = rsp_port.valid && rsp_port.ready;
   assign exec_go        = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_port.ready);

   assign rd_addr = (req_port.kind == bia_pkg::KIND_ALLOC) ? info.free_word :
                    req_port.element[bia_pkg::ELEMENT_W-1:bia_pkg::BIT_IDX_W];

   bia_summary u_summary (
      .clock   (clock),
      .reset   (reset),
      .upd     (upd),
      .rd_addr (addr_ff),
      .info    (info)
   );

   bia_word_ram u_ram (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (ram_data),
      .wr_en   (exec_go && wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_word)
   );

   assign active_limit = (limit_ff > bia_pkg::LIMIT_MAX) ? bia_pkg::LIMIT_MAX : limit_ff;
   assign in_range     = {1'b0, elem_ff} < active_limit;
   assign word         = info.word_valid ? ram_data : '0;

   // lowest free bit of the fetched word
   always_comb begin
      zero_found = 1'b0;
      zero_idx   = '0;
      for (int i = bia_pkg::BITS_PER_WORD - 1; i >= 0; i--) begin
         if (!word[i]) begin
            zero_found = 1'b1;
            zero_idx   = bia_pkg::BIT_IDX_W'(i);
         end
      end
   end

   assign cand = {addr_ff, zero_idx};

   always_comb begin
      status_in  = bia_pkg::ST_OK;
      used_in    = 1'b0;
      granted_in = '0;
      wr_en      = 1'b0;
      bit_idx    = elem_ff[bia_pkg::BIT_IDX_W-1:0];
      upd        = '0;
      case (kind_ff)
         bia_pkg::KIND_SET, bia_pkg::KIND_CLEAR: begin
            if (!in_range) begin
               status_in = bia_pkg::ST_RANGE;
            end else begin
               wr_en = 1'b1;
            end
         end
         bia_pkg::KIND_TEST: begin
            if (!in_range) begin
               status_in = bia_pkg::ST_RANGE;
            end else begin
               used_in = word[bit_idx];
            end
         end
         bia_pkg::KIND_ALLOC: begin
            bit_idx = zero_idx;
            if (free_found_ff && zero_found && ({1'b0, cand} < active_limit)) begin
               wr_en      = 1'b1;
               granted_in = cand;
            end else begin
               status_in = bia_pkg::ST_FULL;
            end
         end
         bia_pkg::KIND_CLEAR_ALL: begin
            upd.clear_all = exec_go;
         end
         default: begin
         end
      endcase
      bit_mask = {{(bia_pkg::BITS_PER_WORD-1){1'b0}}, 1'b1} << bit_idx;
      wr_word  = (kind_ff == bia_pkg::KIND_CLEAR) ? (word & ~bit_mask) : (word | bit_mask);
      upd.wr   = exec_go && wr_en;
      upd.addr = addr_ff;
      upd.full = &wr_word;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign limit_in = csr_we ? csr_wdata : limit_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= bia_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         kind_ff       <= req_port.kind;
         elem_ff       <= req_port.element;
         addr_ff       <= rd_addr;
         free_found_ff <= info.free_found;
      end
      if (exec_go) begin
         status_ff  <= status_in;
         used_ff    <= used_in;
         granted_ff <= granted_in;
      end
   end

   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.status          = status_ff;
   assign rsp_port.is_used         = used_ff;
   assign rsp_port.granted_element = granted_ff;

   `BIA_ASSERT_NEXT(a_accept_to_exec, clock, reset, req_fire, state_ff == ST_EXEC)
   `BIA_ASSERT_NEXT(a_stall_holds_exec, clock, reset,
      (state_ff == ST_EXEC) && rsp_valid_ff && !rsp_port.ready, state_ff == ST_EXEC)
   `BIA_ASSERT_HOLDS(a_used_only_ok, clock, reset,
      rsp_valid_ff && used_ff, status_ff == bia_pkg::ST_OK)
   `BIA_ASSERT_HOLDS(a_fail_no_grant, clock, reset,
      rsp_valid_ff && (status_ff != bia_pkg::ST_OK), granted_ff == '0)

endmodule
